@@ sv/eae_pkg.sv @@
// ----------------------------------------------------------------------------
// eae_pkg
// Shared constants and helper functions of the extended arithmetic element.
// ----------------------------------------------------------------------------
package eae_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CountW = 6;
  localparam int unsigned FlagW  = 8;

  // bus access codes
  localparam logic [OpW-1:0] OP_READ  = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE = 2'd1;
  localparam logic [OpW-1:0] OP_BYTE  = 2'd2;

  // word register indexes (byte_addr >> 1)
  localparam logic [2:0] REG_DIV  = 3'd0;
  localparam logic [2:0] REG_AC   = 3'd1;
  localparam logic [2:0] REG_MQ   = 3'd2;
  localparam logic [2:0] REG_MUL  = 3'd3;
  localparam logic [2:0] REG_SC   = 3'd4;
  localparam logic [2:0] REG_NOR  = 3'd5;
  localparam logic [2:0] REG_LSH  = 3'd6;
  localparam logic [2:0] REG_ASH  = 3'd7;

  // status flag bit positions
  localparam int unsigned F_CARRY = 0;
  localparam int unsigned F_SEXT  = 1;
  localparam int unsigned F_BOTHZ = 2;
  localparam int unsigned F_MQZ   = 3;
  localparam int unsigned F_ACZ   = 4;
  localparam int unsigned F_ACONE = 5;
  localparam int unsigned F_NEG   = 6;
  localparam int unsigned F_OVF   = 7;

  localparam logic [FlagW-1:0] FLAGS_RESET = 8'h1E;
  localparam logic [FlagW-1:0] SC_WR_MASK  = 8'hC1;

  // zero-derived flags from AC and MQ
  function automatic logic [FlagW-1:0] derive_flags(input logic [FlagW-1:0] f,
                                                    input logic [WordW-1:0] ac,
                                                    input logic [WordW-1:0] mq);
    logic [FlagW-1:0] r;
    r          = f;
    r[F_SEXT]  = ((ac == '0) && !mq[WordW-1]) || ((ac == '1) && mq[WordW-1]);
    r[F_BOTHZ] = (ac == '0) && (mq == '0);
    r[F_MQZ]   = (mq == '0);
    r[F_ACZ]   = (ac == '0);
    r[F_ACONE] = (ac == '1);
    return r;
  endfunction

  function automatic logic [WordW-1:0] byte_sext(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

endpackage

@@ sv/eae_if.sv @@
// ----------------------------------------------------------------------------
// eae_in_if / eae_out_if
// Valid/ready channels for bus accesses and read results.
// ----------------------------------------------------------------------------
interface eae_in_if;
  logic                         valid;
  logic                         ready;
  logic [eae_pkg::OpW-1:0]      op;
  logic [eae_pkg::AddrW-1:0]    byte_addr;
  logic [eae_pkg::WordW-1:0]    write_data;
  modport source (output valid, op, byte_addr, write_data, input ready);
  modport sink   (input valid, op, byte_addr, write_data, output ready);
endinterface

interface eae_out_if;
  logic                         valid;
  logic                         ready;
  logic [eae_pkg::WordW-1:0]    read_data;
  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

@@ sv/extended_arithmetic_element_unit.sv @@
// ----------------------------------------------------------------------------
// extended_arithmetic_element_unit
// Register-mapped 16-bit multiply, divide, normalize and shift unit.
// ----------------------------------------------------------------------------
// Each bus beat gives one read beat back. Reads and plain register writes pass
// through decode, then result. Multiply runs 16 add/subtract steps on the
// one 32-bit adder and divide up to 16 steps plus, unless it overflows on the first,
// one correction step; normalize and shifts move one bit per cycle (up to 31 or 32
// steps) and end with a stop test. Each also passes through decode, flag and result
// states. The unit takes no new beat until the result beat has left its output
// register.
module extended_arithmetic_element_unit (
  input  logic     clk,
  input  logic     rst_n,
  eae_in_if.sink   in_ch,
  eae_out_if.source out_ch
);

  localparam int unsigned W  = eae_pkg::WordW;
  localparam int unsigned DW = 2 * W;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_MUL, S_DIV, S_DIVFIX, S_DIVFIX2, S_NORM, S_SHIFT, S_FLAGS, S_OUT
  } state_t;

  typedef enum logic [1:0] {K_LSH, K_ASH} kind_t;

  state_t                         state_r;
  kind_t                          kind_r;
  logic [eae_pkg::OpW-1:0]        op_r;
  logic [eae_pkg::AddrW-1:0]      addr_r;
  logic [W-1:0]                   wd_r;
  logic [W-1:0]                   ac_r, mq_r, x_r, q_r;
  logic [eae_pkg::CountW-1:0]     sc_r;
  logic [eae_pkg::FlagW-1:0]      fl_r;
  logic [DW-1:0]                  acc_r, md_r;
  logic                           prev_r, sgn_r, ov_r, div_ov_r;
  logic [W-1:0]                   rd_r;

  // shared adder
  logic [DW-1:0] add_a, add_b, add_sum;
  logic          add_sub;
  assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

  logic [2:0]   reg_idx;
  logic [W-1:0] sext_b;
  assign reg_idx = addr_r[3:1];
  assign sext_b  = eae_pkg::byte_sext(wd_r[7:0]);

  // divide step helpers
  logic          dv_c;
  logic [DW-1:0] dv_dr;
  assign dv_c  = (md_r[DW-1] == acc_r[DW-1]);
  assign dv_dr = {md_r[DW-1], md_r[DW-1:1]};
  logic [DW-1:0] mag;
  assign mag = md_r[DW-1] ? (DW'(0) - md_r) : md_r;

  // shift step helpers
  logic [DW-1:0] asl;
  assign asl = {acc_r[DW-2:0], 1'b0};

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = (state_r == S_OUT);
  assign out_ch.read_data = rd_r;

  always_comb begin
    add_a   = acc_r;
    add_b   = md_r;
    add_sub = 1'b0;
    unique case (state_r)
      S_MUL: begin
        add_sub = x_r[0];
      end
      S_DIV: begin
        add_b   = dv_dr;
        add_sub = dv_c;
      end
      S_DIVFIX: begin
        add_sub = (acc_r[DW-1] == md_r[DW-1]);
      end
      default: begin
        add_a = acc_r;
      end
    endcase
  end

  // sequencer, registers and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ac_r    <= '0;
      mq_r    <= '0;
      x_r     <= '0;
      sc_r    <= '0;
      fl_r    <= eae_pkg::FLAGS_RESET;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= in_ch.op;
            addr_r  <= in_ch.byte_addr;
            wd_r    <= in_ch.write_data;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          rd_r    <= '0;
          state_r <= S_OUT;
          acc_r   <= {ac_r, mq_r};
          prev_r  <= 1'b0;
          ov_r    <= 1'b0;
          if (op_r == eae_pkg::OP_READ) begin
            unique case (reg_idx)
              eae_pkg::REG_AC:  rd_r <= ac_r;
              eae_pkg::REG_MQ:  rd_r <= mq_r;
              eae_pkg::REG_SC:  rd_r <= {fl_r, 2'b00, sc_r};
              eae_pkg::REG_NOR: rd_r <= {{(W-eae_pkg::CountW){1'b0}}, sc_r};
              default:          rd_r <= '0;
            endcase
          end else if (op_r == eae_pkg::OP_WRITE ||
                       (op_r == eae_pkg::OP_BYTE && !addr_r[0]) ||
                       (op_r == eae_pkg::OP_BYTE && (reg_idx == eae_pkg::REG_AC ||
                                                     reg_idx == eae_pkg::REG_MQ))) begin
            unique case (reg_idx)
              eae_pkg::REG_DIV, eae_pkg::REG_MUL: begin
                x_r   <= (op_r == eae_pkg::OP_BYTE) ? sext_b : wd_r;
                sc_r  <= 6'd16;
                q_r   <= '0;
                sgn_r <= ac_r[W-1];
                if (reg_idx == eae_pkg::REG_MUL) begin
                  md_r    <= {ac_r, mq_r};
                  acc_r   <= '0;
                  state_r <= S_MUL;
                end else begin
                  md_r    <= {(op_r == eae_pkg::OP_BYTE) ? sext_b : wd_r, {W{1'b0}}};
                  fl_r[eae_pkg::F_CARRY] <= 1'b0;
                  state_r <= S_DIV;
                end
              end
              eae_pkg::REG_AC: begin
                if (op_r == eae_pkg::OP_WRITE)  ac_r <= wd_r;
                else if (!addr_r[0])            ac_r <= sext_b;
                else                            ac_r <= {wd_r[15:8], ac_r[7:0]};
              end
              eae_pkg::REG_MQ: begin
                logic [W-1:0] v;
                v = (op_r == eae_pkg::OP_WRITE) ? wd_r :
                    (!addr_r[0]) ? sext_b : {wd_r[15:8], mq_r[7:0]};
                mq_r <= v;
                ac_r <= {W{v[W-1]}};
              end
              eae_pkg::REG_SC: begin
                if (op_r == eae_pkg::OP_WRITE) begin
                  sc_r <= wd_r[5:0];
                  fl_r <= (fl_r & ~eae_pkg::SC_WR_MASK) | (wd_r[15:8] & eae_pkg::SC_WR_MASK);
                end
              end
              eae_pkg::REG_NOR: begin
                sc_r                   <= '0;
                fl_r[eae_pkg::F_CARRY] <= 1'b0;
                fl_r[eae_pkg::F_NEG]   <= ac_r[W-1];
                fl_r[eae_pkg::F_OVF]   <= ac_r[W-1];
                state_r                <= S_NORM;
              end
              default: begin
                sc_r                 <= wd_r[5:0];
                kind_r               <= (reg_idx == eae_pkg::REG_LSH) ? K_LSH : K_ASH;
                fl_r[eae_pkg::F_NEG] <= ac_r[W-1];
                state_r              <= S_SHIFT;
              end
            endcase
          end
        end
        // Booth step: add or subtract shifted multiplicand on a bit change
        S_MUL: begin
          if (x_r[0] != prev_r) acc_r <= add_sum;
          md_r   <= {md_r[DW-2:0], 1'b0};
          prev_r <= x_r[0];
          x_r    <= {1'b0, x_r[W-1:1]};
          sc_r   <= sc_r - 6'd1;
          if (sc_r == 6'd1) begin
            fl_r[eae_pkg::F_CARRY] <= 1'b0;
            state_r <= S_FLAGS;
          end
        end
        // nonrestoring divide step
        S_DIV: begin
          md_r  <= dv_dr;
          q_r   <= {q_r[W-2:0], dv_c};
          acc_r <= add_sum;
          if (sc_r == 6'd16 && add_sum != '0 && add_sum[DW-1] == sgn_r) begin
            ov_r     <= 1'b1;
            div_ov_r <= 1'b1;
            state_r  <= S_DIVFIX2;
          end else begin
            div_ov_r <= 1'b0;
            sc_r     <= sc_r - 6'd1;
            if (sc_r == 6'd1) state_r <= S_DIVFIX;
          end
        end
        // final quotient bit and remainder correction
        S_DIVFIX: begin
          state_r <= S_DIVFIX2;
          if (acc_r == '0 || ((acc_r + mag) != '0 && acc_r[DW-1] == sgn_r)) begin
            q_r <= {q_r[W-2:0], 1'b1};
          end else begin
            acc_r <= add_sum;
            q_r   <= (q_r + {{(W-1){1'b0}}, acc_r[DW-1] == md_r[DW-1]}) << 1;
          end
        end
        // divide overflow and flags
        S_DIVFIX2: begin
          logic ov;
          logic [eae_pkg::FlagW-1:0] f;
          ov = div_ov_r || ((md_r[DW-1] != q_r[W-1]) != sgn_r);
          ac_r <= acc_r[W-1:0];
          mq_r <= q_r;
          f = fl_r;
          f[eae_pkg::F_OVF] = ov != fl_r[eae_pkg::F_NEG];
          f = eae_pkg::derive_flags(f, acc_r[W-1:0], q_r);
          if (ov) f[eae_pkg::F_NEG] = sgn_r;
          fl_r    <= f;
          state_r <= S_OUT;
        end
        // normalize: one left shift a cycle
        S_NORM: begin
          if (acc_r[DW-1] == acc_r[DW-2] && acc_r != 32'hC000_0000 && sc_r != 6'd31) begin
            acc_r <= asl;
            sc_r  <= sc_r + 6'd1;
          end else begin
            state_r <= S_FLAGS;
          end
        end
        // shift: one bit a cycle, bit 5 of count selects right
        S_SHIFT: begin
          if (sc_r == '0) begin
            fl_r[eae_pkg::F_OVF] <= ov_r != fl_r[eae_pkg::F_NEG];
            state_r <= S_FLAGS;
          end else if (sc_r[5]) begin
            fl_r[eae_pkg::F_CARRY] <= acc_r[0];
            if (kind_r == K_LSH) begin
              acc_r <= {1'b0, acc_r[DW-1:1]};
              fl_r[eae_pkg::F_NEG] <= 1'b0;
            end else begin
              acc_r <= {fl_r[eae_pkg::F_NEG], acc_r[DW-1:1]};
            end
            sc_r <= sc_r + 6'd1;
          end else if (kind_r == K_LSH) begin
            fl_r[eae_pkg::F_CARRY] <= acc_r[DW-1];
            acc_r <= asl;
            if (fl_r[eae_pkg::F_NEG] != asl[DW-1]) ov_r <= 1'b1;
            fl_r[eae_pkg::F_NEG] <= asl[DW-1];
            sc_r <= sc_r - 6'd1;
          end else begin
            fl_r[eae_pkg::F_CARRY] <= asl[DW-1];
            acc_r <= {fl_r[eae_pkg::F_NEG], asl[DW-2:0]};
            if (asl[DW-1] != fl_r[eae_pkg::F_NEG]) ov_r <= 1'b1;
            sc_r <= sc_r - 6'd1;
          end
        end
        // write AC:MQ back and refresh zero flags
        S_FLAGS: begin
          ac_r    <= acc_r[DW-1:W];
          mq_r    <= acc_r[W-1:0];
          fl_r    <= eae_pkg::derive_flags(fl_r, acc_r[DW-1:W], acc_r[W-1:0]);
          state_r <= S_OUT;
        end
        // hold result beat until taken
        S_OUT: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.read_data))
    else $error("result beat dropped");
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_DEC) else $error("accept lost");
  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> sc_r != '0) else $error("multiply count ran out");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the extended arithmetic element unit against a cycle-free predictor
// of its register file, multiply, divide, normalize and shift operations.
// Bus beats are sent with random gaps and results are taken with random
// stalls for part of the run; every read beat is compared with the predicted value.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [eae_pkg::OpW-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned    CYCLE_LIMIT = 600000;
  localparam int unsigned    HOLD_CYCLES = 400;
  localparam int unsigned    DRAIN_CYCLES = 60;

  logic clk;
  logic rst_n;

  eae_in_if  in_ch ();
  eae_out_if out_ch ();

  extended_arithmetic_element_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted unit state
  logic [eae_pkg::WordW-1:0]  ac_q, mq_q, opx_q;
  logic [eae_pkg::CountW-1:0] sc_q;
  logic [eae_pkg::FlagW-1:0]  flags_q;

  logic [eae_pkg::WordW-1:0] read_queue[$];
  int unsigned beats_sent, results_seen, errors, cycles;
  bit  gaps_on, stalls_on, hold_req;

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, read_queue.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic void refresh_status();
    flags_q[eae_pkg::F_SEXT]  = (ac_q == '0 && !mq_q[15]) || (ac_q == '1 && mq_q[15]);
    flags_q[eae_pkg::F_BOTHZ] = (ac_q == '0) && (mq_q == '0);
    flags_q[eae_pkg::F_MQZ]   = (mq_q == '0);
    flags_q[eae_pkg::F_ACZ]   = (ac_q == '0);
    flags_q[eae_pkg::F_ACONE] = (ac_q == '1);
  endfunction

  function automatic logic [eae_pkg::WordW-1:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

  function automatic void load_mq_pred(input logic [eae_pkg::WordW-1:0] v);
    mq_q = v;
    ac_q = {eae_pkg::WordW{v[15]}};
  endfunction

  function automatic void multiply_pred();
    logic [31:0] sum, md;
    logic        prev, b;
    sum = '0;
    md = {ac_q, mq_q};
    prev = 1'b0;
    for (int i = 0; i < 16; i++) begin
      b = opx_q[0];
      if (b != prev) sum = b ? sum - md : sum + md;
      md = md << 1;
      prev = b;
      opx_q = opx_q >> 1;
    end
    sc_q = '0;
    {ac_q, mq_q} = sum;
    flags_q[eae_pkg::F_CARRY] = 1'b0;
    refresh_status();
  endfunction

  function automatic void divide_pred();
    logic [31:0] dd, dr, mag;
    logic [15:0] q;
    logic        s, c, ov, early;
    dd = {ac_q, mq_q};
    dr = {opx_q, 16'h0};
    q = '0;
    s = dd[31];
    ov = 1'b0;
    early = 1'b0;
    flags_q[eae_pkg::F_CARRY] = 1'b0;
    sc_q = 6'd16;
    while (sc_q != 6'd0 && !early) begin
      c = (dr[31] == dd[31]);
      dr = dr >> 1;
      if (dr[30]) dr[31] = 1'b1;
      q = {q[14:0], c};
      dd = c ? dd - dr : dd + dr;
      if (sc_q == 6'd16 && dd != 0 && dd[31] == s) early = 1'b1;
      else sc_q = sc_q - 6'd1;
    end
    if (early) begin
      ov = 1'b1;
    end else begin
      mag = dr[31] ? (32'h0 - dr) : dr;
      if (dd == 0 || ((dd + mag) != 0 && dd[31] == s)) begin
        q = {q[14:0], 1'b1};
      end else begin
        c = (dd[31] == dr[31]);
        dd = c ? dd - dr : dd + dr;
        q = q + {15'h0, c};
        q = q << 1;
      end
      if ((dr[31] != q[15]) != s) ov = 1'b1;
    end
    ac_q = dd[15:0];
    mq_q = q;
    flags_q[eae_pkg::F_OVF] = ov != flags_q[eae_pkg::F_NEG];
    refresh_status();
    if (ov) flags_q[eae_pkg::F_NEG] = s;
  endfunction

  function automatic void normalize_pred();
    logic [31:0] sh;
    sh = {ac_q, mq_q};
    sc_q = '0;
    flags_q[eae_pkg::F_OVF] = 1'b0;
    flags_q[eae_pkg::F_CARRY] = 1'b0;
    flags_q[eae_pkg::F_NEG] = sh[31];
    if (flags_q[eae_pkg::F_NEG]) flags_q[eae_pkg::F_OVF] = 1'b1;
    while (sh[31] == sh[30] && sh != 32'hC000_0000 && sc_q != 6'd31) begin
      sh = sh << 1;
      sc_q = sc_q + 6'd1;
    end
    {ac_q, mq_q} = sh;
    refresh_status();
  endfunction

  function automatic void shift_pred(input logic arith);
    logic [31:0] sh;
    logic        ov;
    sh = {ac_q, mq_q};
    ov = 1'b0;
    flags_q[eae_pkg::F_NEG] = sh[31];
    while (sc_q != 6'd0) begin
      if (sc_q[5]) begin
        // right by one, count up toward zero
        flags_q[eae_pkg::F_CARRY] = sh[0];
        sh = sh >> 1;
        if (!arith) flags_q[eae_pkg::F_NEG] = 1'b0;
        else if (flags_q[eae_pkg::F_NEG]) sh[31] = 1'b1;
        sc_q = sc_q + 6'd1;
      end else if (!arith) begin
        flags_q[eae_pkg::F_CARRY] = sh[31];
        sh = sh << 1;
        if (flags_q[eae_pkg::F_NEG] != sh[31]) ov = 1'b1;
        flags_q[eae_pkg::F_NEG] = sh[31];
        sc_q = sc_q - 6'd1;
      end else begin
        sh = sh << 1;
        flags_q[eae_pkg::F_CARRY] = sh[31];
        sh[31] = flags_q[eae_pkg::F_NEG];
        if (flags_q[eae_pkg::F_CARRY] != flags_q[eae_pkg::F_NEG]) ov = 1'b1;
        sc_q = sc_q - 6'd1;
      end
    end
    flags_q[eae_pkg::F_OVF] = ov != flags_q[eae_pkg::F_NEG];
    {ac_q, mq_q} = sh;
    refresh_status();
  endfunction

  // apply one bus beat to the predicted state, return the read value
  function automatic logic [eae_pkg::WordW-1:0] access_pred(
      input logic [eae_pkg::OpW-1:0] op,
      input logic [eae_pkg::AddrW-1:0] addr,
      input logic [eae_pkg::WordW-1:0] d);
    logic [eae_pkg::WordW-1:0] rd;
    rd = '0;
    case (op)
      eae_pkg::OP_READ: begin
        case (addr[3:1])
          eae_pkg::REG_AC:  rd = ac_q;
          eae_pkg::REG_MQ:  rd = mq_q;
          eae_pkg::REG_SC:  rd = {flags_q, 2'b00, sc_q};
          eae_pkg::REG_NOR: rd = {10'h0, sc_q};
          default: rd = '0;
        endcase
      end
      eae_pkg::OP_WRITE: begin
        case (addr[3:1])
          eae_pkg::REG_DIV: begin opx_q = d; divide_pred(); end
          eae_pkg::REG_AC:  ac_q = d;
          eae_pkg::REG_MQ:  load_mq_pred(d);
          eae_pkg::REG_MUL: begin opx_q = d; multiply_pred(); end
          eae_pkg::REG_SC: begin
            sc_q = d[5:0];
            flags_q = (flags_q & ~eae_pkg::SC_WR_MASK) | (d[15:8] & eae_pkg::SC_WR_MASK);
          end
          eae_pkg::REG_NOR: normalize_pred();
          eae_pkg::REG_LSH: begin sc_q = d[5:0]; shift_pred(1'b0); end
          default: begin sc_q = d[5:0]; shift_pred(1'b1); end
        endcase
      end
      eae_pkg::OP_BYTE: begin
        case (addr)
          {eae_pkg::REG_DIV, 1'b0}: begin opx_q = sext8(d[7:0]); divide_pred(); end
          {eae_pkg::REG_AC, 1'b0}:  ac_q = sext8(d[7:0]);
          {eae_pkg::REG_AC, 1'b1}:  ac_q = {d[15:8], ac_q[7:0]};
          {eae_pkg::REG_MQ, 1'b0}:  load_mq_pred(sext8(d[7:0]));
          {eae_pkg::REG_MQ, 1'b1}:  load_mq_pred({d[15:8], mq_q[7:0]});
          {eae_pkg::REG_MUL, 1'b0}: begin opx_q = sext8(d[7:0]); multiply_pred(); end
          {eae_pkg::REG_NOR, 1'b0}: normalize_pred();
          {eae_pkg::REG_LSH, 1'b0}: begin sc_q = d[5:0]; shift_pred(1'b0); end
          {eae_pkg::REG_ASH, 1'b0}: begin sc_q = d[5:0]; shift_pred(1'b1); end
          default: ;
        endcase
      end
      default: ;
    endcase
    return rd;
  endfunction

  // ---------------------------------------------------------------- driver
  task automatic send_beat(input logic [eae_pkg::OpW-1:0] op,
                           input logic [eae_pkg::AddrW-1:0] addr,
                           input logic [eae_pkg::WordW-1:0] d);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.byte_addr  <= addr;
    in_ch.write_data <= d;
    do @(posedge clk); while (!in_ch.ready);
    read_queue.push_back(access_pred(op, addr, d));
    beats_sent++;
  endtask

  task automatic send_word(input logic [2:0] reg_idx,
                           input logic [eae_pkg::WordW-1:0] d);
    send_beat(eae_pkg::OP_WRITE, {reg_idx, 1'b0}, d);
  endtask

  task automatic read_word(input logic [2:0] reg_idx);
    send_beat(eae_pkg::OP_READ, {reg_idx, 1'b0}, 16'($urandom));
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (read_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the unit fills up and stalls its input
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (read_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time,
                 out_ch.read_data);
        errors++;
      end else begin
        if (out_ch.read_data !== read_queue[0]) begin
          $display("%0t: read_data mismatch, expected %h, actual %h", $time,
                   read_queue[0], out_ch.read_data);
          errors++;
        end
        void'(read_queue.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_registers();
    for (int a = 0; a < 8; a++) read_word(a[2:0]);
    send_word(eae_pkg::REG_AC, 16'hFFFF);
    send_word(eae_pkg::REG_MQ, 16'h8000);
    send_beat(eae_pkg::OP_READ, {eae_pkg::REG_AC, 1'b1}, 16'h0);   // odd byte address
    for (int a = 0; a < 16; a++) send_beat(eae_pkg::OP_BYTE, a[3:0], 16'hA5C3);
    send_beat(OP_UNUSED, {eae_pkg::REG_AC, 1'b0}, 16'hFFFF);
    send_word(eae_pkg::REG_SC, 16'hFFFF);
    read_word(eae_pkg::REG_SC);
    send_word(eae_pkg::REG_SC, 16'h0000);
    read_word(eae_pkg::REG_SC);
  endtask

  task automatic test_arith();
    send_word(eae_pkg::REG_MQ, 16'h7FFF);
    send_word(eae_pkg::REG_MUL, 16'h8000);
    read_word(eae_pkg::REG_AC);
    send_word(eae_pkg::REG_AC, 16'h0000);
    send_word(eae_pkg::REG_DIV, 16'h0000);         // overflow on first step
    read_word(eae_pkg::REG_SC);
    send_word(eae_pkg::REG_MQ, 16'd1000);
    send_word(eae_pkg::REG_DIV, 16'hFFF9);
    read_word(eae_pkg::REG_MQ);
    send_word(eae_pkg::REG_AC, 16'h0000);
    send_word(eae_pkg::REG_MQ, 16'h0000);
    send_word(eae_pkg::REG_NOR, 16'h0);            // zero pair stops at 31
    read_word(eae_pkg::REG_NOR);
    send_word(eae_pkg::REG_AC, 16'hC000);
    send_word(eae_pkg::REG_NOR, 16'h0);
    send_word(eae_pkg::REG_LSH, 16'h001F);
    send_word(eae_pkg::REG_ASH, 16'h0020);
    send_word(eae_pkg::REG_LSH, 16'h003F);
    send_word(eae_pkg::REG_ASH, 16'h001F);
    read_word(eae_pkg::REG_SC);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_word(eae_pkg::REG_MUL, 16'($urandom));
    wait_drain();
  endtask

  task automatic random_beat();
    int unsigned pick;
    logic [eae_pkg::WordW-1:0] d;
    logic [eae_pkg::WordW-1:0] r;
    pick = $urandom_range(0, 99);
    d = 16'($urandom);
    r = 16'($urandom);
    if (pick < 30) begin
      // well-formed divide whose dividend fits the divisor
      send_word(eae_pkg::REG_AC, d[15] ? ~(r & 16'h3FFF) : (r & 16'h3FFF));
      send_word(eae_pkg::REG_MQ, 16'($urandom));
      send_word(eae_pkg::REG_DIV, 16'($urandom) | 16'h4000);
      read_word($urandom_range(0, 1) ? eae_pkg::REG_MQ : eae_pkg::REG_AC);
      read_word(eae_pkg::REG_SC);
    end else if (pick < 50) begin
      send_word(eae_pkg::REG_MQ, d);
      send_word($urandom_range(0, 1) ? eae_pkg::REG_AC : eae_pkg::REG_NOR, r);
      send_beat($urandom_range(0, 3) == 0 ? eae_pkg::OP_BYTE : eae_pkg::OP_WRITE,
                {3'($urandom_range(3, 7)), 1'b0}, 16'($urandom));
      read_word(3'($urandom_range(0, 7)));
    end else if (pick < 90) begin
      send_beat(2'($urandom_range(0, 2)), 4'($urandom), d);
    end else begin
      send_beat(2'($urandom_range(0, 3)), 4'($urandom), d);
    end
  endtask

  task automatic test_random(input int unsigned count);
    for (int i = 0; i < count; i++) random_beat();
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = eae_pkg::OP_READ;
    in_ch.byte_addr = '0;
    in_ch.write_data = '0;
    {beats_sent, results_seen, errors} = '0;
    {gaps_on, stalls_on, hold_req} = '0;
    ac_q = '0;
    mq_q = '0;
    opx_q = '0;
    sc_q = '0;
    flags_q = eae_pkg::FLAGS_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_registers();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_arith();
    test_backpressure();
    test_random(500);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_random(85);
    wait_drain();

    $display("Sent %0d bus beats and checked %0d read beats", beats_sent, results_seen);
    $display("Covered register access, multiply, divide, normalize, shifts, stalls");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/eae_pkg.sv
sv/eae_if.sv
sv/extended_arithmetic_element_unit.sv
sim/testbench.sv
